/* rtl/core/ini_line_tokenizer_top_defines.svh */
// ============================================================================
// INI line tokenizer assertion macros
// Shared concurrent assertion forms for the tokenizer checker.
// ============================================================================
`ifndef INI_LINE_TOKENIZER_TOP_DEFINES_SVH
`define INI_LINE_TOKENIZER_TOP_DEFINES_SVH

// Implication checked at every clock, masked while reset is asserted.
`define ILT_ASSERT_IMPL(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define ILT_ASSERT_NEXT(label, clk, rstn, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

/* rtl/core/ilt_pkg.sv */
// ============================================================================
// INI line tokenizer package
// Parse modes, token classes, character codes and beat structures.
// ============================================================================
package ilt_pkg;

    typedef enum logic [2:0] {
        MODE_LINE_START = 3'd0,
        MODE_MID_LINE   = 3'd1,
        MODE_SECTION    = 3'd2,
        MODE_SECTION_ESC = 3'd3,
        MODE_KEY        = 3'd4,
        MODE_KEY_ESC    = 3'd5,
        MODE_VALUE_RAW  = 3'd6,
        MODE_VALUE      = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        CLASS_SECTION = 2'd0,
        CLASS_KEY     = 2'd1,
        CLASS_VALUE   = 2'd2
    } token_class_t;

    localparam logic [7:0] CH_OPEN   = 8'h5B;
    localparam logic [7:0] CH_CLOSE  = 8'h5D;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_ESCAPE = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [7:0] SECTION_LIMIT_RESET = 8'd49;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        token_class_t token_class;
        logic         char_valid;
        logic [7:0]   char_byte;
        logic         token_end;
    } result_t;

endpackage

/* rtl/core/ilt_in_stage.sv */
// ============================================================================
// INI line tokenizer input stage
// Registers one input beat and hands it to the parser.
// ============================================================================
module ilt_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] text_byte
    input  logic              s_tlast,   // end_of_input
    input  logic              advance,
    output logic              item_valid,
    output ilt_pkg::in_item_t item
);

    logic              valid_reg;
    logic              valid_next;
    ilt_pkg::in_item_t item_reg;

    // Take a beat when empty or when the held beat moves on this cycle;
    // hold off while reset is asserted so no beat is dropped.
    assign s_tready   = aresetn && (!valid_reg || advance);
    assign valid_next = s_tvalid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.text_byte    <= s_tdata;
            item_reg.end_of_input <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/core/ilt_parser.sv */
// ============================================================================
// INI line tokenizer parser
// Mode state machine and section counter; decodes one byte per step.
// ============================================================================
module ilt_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  ilt_pkg::in_item_t item,
    input  logic [7:0]        section_limit,
    output logic              emit,
    output ilt_pkg::result_t  result
);

    ilt_pkg::mode_t mode_reg;
    ilt_pkg::mode_t mode_next;
    ilt_pkg::mode_t step_mode;
    logic [7:0]     count_reg;
    logic [7:0]     count_next;
    logic [7:0]     count_step;
    logic [7:0]     count_inc;
    logic           sec_full;
    logic [7:0]     b;
    logic           last;

    assign b         = item.text_byte;
    assign last      = item.end_of_input;
    assign count_inc = count_reg + 8'd1;
    assign sec_full  = (count_inc >= section_limit);

    // Next state
    always_comb begin
        step_mode  = mode_reg;
        count_step = count_reg;
        unique case (mode_reg)
            ilt_pkg::MODE_LINE_START, ilt_pkg::MODE_MID_LINE: begin
                if (b == ilt_pkg::CH_CR) begin
                    step_mode = mode_reg;
                end else if (b == ilt_pkg::CH_LF) begin
                    step_mode = ilt_pkg::MODE_LINE_START;
                end else if (mode_reg == ilt_pkg::MODE_LINE_START &&
                             b == ilt_pkg::CH_OPEN) begin
                    count_step = 8'd0;
                    step_mode  = (section_limit == 8'd0) ? ilt_pkg::MODE_MID_LINE
                                                         : ilt_pkg::MODE_SECTION;
                end else begin
                    step_mode = ilt_pkg::MODE_KEY;
                end
            end
            ilt_pkg::MODE_SECTION: begin
                if (b == ilt_pkg::CH_ESCAPE) begin
                    step_mode = ilt_pkg::MODE_SECTION_ESC;
                end else if (b == ilt_pkg::CH_CLOSE) begin
                    step_mode = ilt_pkg::MODE_MID_LINE;
                end else begin
                    count_step = count_inc;
                    step_mode  = sec_full ? ilt_pkg::MODE_MID_LINE : ilt_pkg::MODE_SECTION;
                end
            end
            ilt_pkg::MODE_SECTION_ESC: begin
                count_step = count_inc;
                step_mode  = sec_full ? ilt_pkg::MODE_MID_LINE : ilt_pkg::MODE_SECTION;
            end
            ilt_pkg::MODE_KEY: begin
                if (b == ilt_pkg::CH_ESCAPE) begin
                    step_mode = ilt_pkg::MODE_KEY_ESC;
                end else if (b == ilt_pkg::CH_LF || b == ilt_pkg::CH_EQUALS) begin
                    step_mode = ilt_pkg::MODE_VALUE_RAW;
                end
            end
            ilt_pkg::MODE_KEY_ESC: begin
                step_mode = ilt_pkg::MODE_KEY;
            end
            ilt_pkg::MODE_VALUE_RAW: begin
                step_mode = ilt_pkg::MODE_VALUE;
            end
            ilt_pkg::MODE_VALUE: begin
                if (b == ilt_pkg::CH_ESCAPE) begin
                    step_mode = ilt_pkg::MODE_VALUE_RAW;
                end else if (b == ilt_pkg::CH_LF) begin
                    step_mode = ilt_pkg::MODE_LINE_START;
                end
            end
            default: begin
                step_mode = ilt_pkg::MODE_LINE_START;
            end
        endcase
        // Last byte: drop back to line start.
        mode_next  = last ? ilt_pkg::MODE_LINE_START : step_mode;
        count_next = last ? 8'd0 : count_step;
    end

    // Outputs
    always_comb begin
        logic         have;
        logic         open_tok;
        ilt_pkg::token_class_t cls;
        logic         valid;
        logic         tok_end;
        have     = 1'b0;
        cls      = ilt_pkg::CLASS_SECTION;
        valid    = 1'b0;
        tok_end  = 1'b0;
        open_tok = 1'b0;
        unique case (mode_reg)
            ilt_pkg::MODE_LINE_START, ilt_pkg::MODE_MID_LINE: begin
                if (b == ilt_pkg::CH_CR || b == ilt_pkg::CH_LF) begin
                    have = 1'b0;
                end else if (mode_reg == ilt_pkg::MODE_LINE_START &&
                             b == ilt_pkg::CH_OPEN) begin
                    // Empty section when the limit is zero.
                    have    = (section_limit == 8'd0);
                    tok_end = 1'b1;
                end else begin
                    have  = 1'b1;
                    cls   = ilt_pkg::CLASS_KEY;
                    valid = 1'b1;
                end
            end
            ilt_pkg::MODE_SECTION: begin
                if (b == ilt_pkg::CH_ESCAPE) begin
                    have = 1'b0;
                end else if (b == ilt_pkg::CH_CLOSE) begin
                    have    = 1'b1;
                    tok_end = 1'b1;
                end else begin
                    have    = 1'b1;
                    valid   = 1'b1;
                    tok_end = sec_full;
                end
            end
            ilt_pkg::MODE_SECTION_ESC: begin
                have    = 1'b1;
                valid   = 1'b1;
                tok_end = sec_full;
            end
            ilt_pkg::MODE_KEY: begin
                cls = ilt_pkg::CLASS_KEY;
                if (b == ilt_pkg::CH_ESCAPE || b == ilt_pkg::CH_CR) begin
                    have = 1'b0;
                end else if (b == ilt_pkg::CH_LF || b == ilt_pkg::CH_EQUALS) begin
                    have    = 1'b1;
                    tok_end = 1'b1;
                end else begin
                    have  = 1'b1;
                    valid = 1'b1;
                end
            end
            ilt_pkg::MODE_KEY_ESC: begin
                have  = 1'b1;
                cls   = ilt_pkg::CLASS_KEY;
                valid = 1'b1;
            end
            ilt_pkg::MODE_VALUE_RAW: begin
                have  = 1'b1;
                cls   = ilt_pkg::CLASS_VALUE;
                valid = 1'b1;
            end
            ilt_pkg::MODE_VALUE: begin
                cls = ilt_pkg::CLASS_VALUE;
                if (b == ilt_pkg::CH_ESCAPE || b == ilt_pkg::CH_CR) begin
                    have = 1'b0;
                end else if (b == ilt_pkg::CH_LF) begin
                    have    = 1'b1;
                    tok_end = 1'b1;
                end else begin
                    have  = 1'b1;
                    valid = 1'b1;
                end
            end
            default: begin
                have = 1'b0;
            end
        endcase

        // Last byte closes a token that is still open after this step.
        open_tok = (step_mode != ilt_pkg::MODE_LINE_START) &&
                   (step_mode != ilt_pkg::MODE_MID_LINE);
        if (last && !(have && tok_end) && open_tok) begin
            if (have) begin
                tok_end = 1'b1;
            end else begin
                have    = 1'b1;
                valid   = 1'b0;
                tok_end = 1'b1;
                if (step_mode == ilt_pkg::MODE_SECTION ||
                    step_mode == ilt_pkg::MODE_SECTION_ESC) begin
                    cls = ilt_pkg::CLASS_SECTION;
                end else if (step_mode == ilt_pkg::MODE_KEY ||
                             step_mode == ilt_pkg::MODE_KEY_ESC) begin
                    cls = ilt_pkg::CLASS_KEY;
                end else begin
                    cls = ilt_pkg::CLASS_VALUE;
                end
            end
        end

        emit               = have;
        result.token_class = cls;
        result.char_valid  = valid;
        result.char_byte   = valid ? b : 8'd0;
        result.token_end   = tok_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= ilt_pkg::MODE_LINE_START;
            count_reg <= 8'd0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/core/ilt_out_stage.sv */
// ============================================================================
// INI line tokenizer output stage
// Holds one result beat until the downstream side takes it.
// ============================================================================
module ilt_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  ilt_pkg::result_t result,
    output logic             busy,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] char_byte
    output logic [2:0]       m_tuser,   // [1:0] token_class, [2] char_valid
    output logic             m_tlast    // token_end
);

    logic             valid_reg;
    ilt_pkg::result_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    // Full and not drained this cycle.
    assign busy     = valid_reg && !m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg.char_byte;
    assign m_tuser  = {data_reg.char_valid, data_reg.token_class};
    assign m_tlast  = data_reg.token_end;

endmodule

/* rtl/core/ini_line_tokenizer_top.sv */
// ============================================================================
// INI line tokenizer top level
// Streams INI text one byte per beat and emits tagged token characters.
// ============================================================================
// The block takes one byte of INI-style text per input beat and returns zero
// or one result beat per byte: a section, key or value character, or an
// end-of-token marker. It accepts a new byte every cycle unless backpressure
// stalls it; a byte is held in the input register and, when it moves on,
// its result is loaded into the output register through the combinational
// mode update. A byte that produces no result (CR, backslash, '[' at line
// start with a nonzero section_limit) still moves on while the output
// register is full. Backpressure on m_tready stalls the input only when a
// result is waiting and the held byte would produce another.
// section_limit resets to 49; the user writes it through cfg_wr_en /
// cfg_wr_data only while the stream is idle; the block does not enforce it.
// ============================================================================
module ini_line_tokenizer_top (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration: section_limit
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // Input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] text_byte
    input  logic       s_tlast,    // end_of_input
    // Result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] char_byte
    output logic [2:0] m_tuser,    // [1:0] token_class, [2] char_valid
    output logic       m_tlast     // token_end
);

    logic [7:0]        limit_reg;
    logic              item_valid;
    ilt_pkg::in_item_t item;
    logic              emit;
    ilt_pkg::result_t  result;
    logic              out_busy;
    logic              advance;

    // Hold the section limit; the user writes it only while the stream is idle, unchecked here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= ilt_pkg::SECTION_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Advance the held byte unless its result would overwrite a waiting one.
    assign advance = item_valid && !(emit && out_busy);

    ilt_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ilt_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .item          (item),
        .section_limit (limit_reg),
        .emit          (emit),
        .result        (result)
    );

    ilt_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && emit),
        .result   (result),
        .busy     (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/core/ilt_checker.sv */
// ============================================================================
// INI line tokenizer checker
// Port-level assertions on the result stream, bound to the top level.
// ============================================================================
`include "ini_line_tokenizer_top_defines.svh"

module ilt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result beat holds its payload.
    `ILT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser, m_tlast}), "result beat changed while stalled")

    // A beat without a character is always an end marker.
    `ILT_ASSERT_IMPL(a_marker_end, aclk, aresetn, m_tvalid && !m_tuser[2], m_tlast, "marker beat without token end")

    // A marker carries a zero character byte.
    `ILT_ASSERT_IMPL(a_marker_zero, aclk, aresetn, m_tvalid && !m_tuser[2], m_tdata == 8'd0, "marker beat with nonzero byte")

    // Token class never takes the unused code.
    `ILT_ASSERT_IMPL(a_class_code, aclk, aresetn, m_tvalid, m_tuser[1:0] != 2'd3, "token class out of range")

endmodule

bind ini_line_tokenizer_top ilt_checker u_ilt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
